// ----- rtl/core/tccw_pkg.sv -----
// Shared types, codes and constants for the text console cell writer.
package tccw_pkg;

   // Screen geometry defaults
   localparam int SCREEN_COLUMNS_DEF = 80;
   localparam int SCREEN_ROWS_DEF    = 25;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int NUMBER_W = 32;
   localparam int ADDR_W   = 11;
   localparam int WORD_W   = 16;
   localparam int ATTR_W   = 8;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int DIGIT_W  = 4;

   // Decimal conversion
   localparam int DIGITS_MAX               = 10;
   localparam int DIGIT_IDX_W              = 4;
   localparam logic [31:0] RECIP_TEN       = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT              = 35;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PRINT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
   localparam logic [CHAR_W-1:0] ZERO_CODE    = 8'd48;
   localparam logic [CHAR_W-1:0] MINUS_CODE   = 8'd45;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_PUT,
      SEQ_SIGN,
      SEQ_CONVERT,
      SEQ_DIGITS,
      SEQ_FILL
   } seq_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_SPLIT
   } div_state_type;

   typedef struct packed {
      logic                   done;
      logic [DIGIT_IDX_W-1:0] count;
   } div_status_type;

   typedef struct packed {
      logic put;
      logic newline;
      logic home;
   } cursor_cmd_type;

endpackage

// ----- rtl/core/tccw_ifs.sv -----
// Valid/ready channel interfaces for request, response and attribute write.
interface tccw_req_if;
   logic                                valid;
   logic                                ready;
   logic [tccw_pkg::CMD_W-1:0]          cmd;
   logic [tccw_pkg::CHAR_W-1:0]         char_code;
   logic signed [tccw_pkg::NUMBER_W-1:0] number;

   modport source (output valid, output cmd, output char_code, output number, input ready);
   modport sink   (input valid, input cmd, input char_code, input number, output ready);
endinterface

interface tccw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tccw_pkg::ADDR_W-1:0]  cell_address;
   logic [tccw_pkg::WORD_W-1:0]  cell_word;
   logic                         fill_all;
   logic                         last;

   modport source (output valid, output cell_address, output cell_word, output fill_all,
                   output last, input ready);
   modport sink   (input valid, input cell_address, input cell_word, input fill_all,
                   input last, output ready);
endinterface

interface tccw_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tccw_pkg::ATTR_W-1:0]  text_attribute;

   modport source (output valid, output text_attribute, input ready);
   modport sink   (input valid, input text_attribute, output ready);
endinterface

// ----- rtl/core/text_console_cell_writer_top.sv -----
// Top level of the text console cell writer: command sequencer and output register.
//
//   channel   | dir | transfer carries
//   ----------+-----+-----------------------------------------------
//   req_chan  | in  | cmd, char_code, number
//   rsp_chan  | out | cell_address, cell_word, fill_all, last
//   csr_chan  | in  | text_attribute (always ready)
//
// Put: the request is accepted in idle, then the put state loads the output register with
// the cell write once the slot is free, and the request side reopens with that load.
// A newline put sends nothing and only moves the cursor. Clear: one fill transfer.
// Print: the divide-by-ten unit makes each digit with one reciprocal multiply and one split;
// the sequencer then picks up the digit count and sends the digits, most significant first;
// the minus sign goes out while the divider runs.
// Synchronous active-high reset clears the cursor and sequencer and sets the attribute to 0x0F.
// A stalled rsp_chan holds the output register; the sequencer waits and no result drops.
module text_console_cell_writer_top #(
   parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = tccw_pkg::SCREEN_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tccw_req_if.sink    req_chan,
   tccw_rsp_if.source  rsp_chan,
   tccw_csr_if.sink    csr_chan
);

   localparam int SCREEN_AREA = SCREEN_COLUMNS * SCREEN_ROWS;

   tccw_pkg::seq_state_type state_ff, state_in;

   // Latched request data
   logic [tccw_pkg::CHAR_W-1:0]       char_ff, char_in;
   logic [tccw_pkg::DIGIT_IDX_W-1:0]  idx_ff, idx_in;
   logic [tccw_pkg::ATTR_W-1:0]       attr_ff, attr_in;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tccw_pkg::ADDR_W-1:0]       rsp_addr_ff;
   logic [tccw_pkg::WORD_W-1:0]       rsp_word_ff;
   logic                              rsp_fill_ff;
   logic                              rsp_last_ff;

   logic                              req_accept;
   logic                              slot_free;
   logic                              is_newline;
   logic [tccw_pkg::NUMBER_W-1:0]     num_bits;
   logic [tccw_pkg::NUMBER_W-1:0]     num_mag;

   // Sequencer outputs
   logic                              emit;
   logic [tccw_pkg::CHAR_W-1:0]       emit_char;
   logic                              emit_fill;
   logic                              emit_last;
   logic                              div_start;
   tccw_pkg::cursor_cmd_type          cursor_cmd;

   logic [tccw_pkg::ADDR_W-1:0]       cursor_addr;
   logic [tccw_pkg::DIGIT_W-1:0]      digit;
   tccw_pkg::div_status_type          div_status;

   assign req_chan.ready = (state_ff == tccw_pkg::SEQ_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Room for a new result: register empty or being drained this cycle
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign is_newline = (char_ff == tccw_pkg::NEWLINE_CODE);

   // Two's-complement magnitude; the most negative value stays 0x8000_0000
   assign num_bits = req_chan.number;
   assign num_mag  = num_bits[tccw_pkg::NUMBER_W-1] ? (~num_bits + 1'b1) : num_bits;

   tccw_div10 u_div10 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .value    (num_mag),
      .rd_index (idx_ff),
      .rd_digit (digit),
      .status   (div_status)
   );

   tccw_cursor #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_cursor (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cursor_cmd),
      .cell_address (cursor_addr)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccw_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               unique case (req_chan.cmd)
                  tccw_pkg::CMD_PUT:   state_in = tccw_pkg::SEQ_PUT;
                  tccw_pkg::CMD_PRINT: state_in = num_bits[tccw_pkg::NUMBER_W-1]
                                                  ? tccw_pkg::SEQ_SIGN
                                                  : tccw_pkg::SEQ_CONVERT;
                  tccw_pkg::CMD_CLEAR: state_in = tccw_pkg::SEQ_FILL;
                  default:             state_in = tccw_pkg::SEQ_IDLE;
               endcase
            end
         end
         tccw_pkg::SEQ_PUT: begin
            if (is_newline || slot_free) state_in = tccw_pkg::SEQ_IDLE;
         end
         tccw_pkg::SEQ_SIGN: begin
            if (slot_free) state_in = tccw_pkg::SEQ_CONVERT;
         end
         tccw_pkg::SEQ_CONVERT: begin
            if (div_status.done) state_in = tccw_pkg::SEQ_DIGITS;
         end
         tccw_pkg::SEQ_DIGITS: begin
            if (slot_free && idx_ff == '0) state_in = tccw_pkg::SEQ_IDLE;
         end
         tccw_pkg::SEQ_FILL: begin
            if (slot_free) state_in = tccw_pkg::SEQ_IDLE;
         end
         default: state_in = tccw_pkg::SEQ_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      emit       = 1'b0;
      emit_char  = char_ff;
      emit_fill  = 1'b0;
      emit_last  = 1'b0;
      div_start  = 1'b0;
      cursor_cmd = '0;
      char_in    = char_ff;
      idx_in     = idx_ff;
      unique case (state_ff)
         tccw_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               char_in   = req_chan.char_code;
               div_start = (req_chan.cmd == tccw_pkg::CMD_PRINT);
            end
         end
         tccw_pkg::SEQ_PUT: begin
            if (is_newline) begin
               cursor_cmd.newline = 1'b1;
            end else begin
               emit      = slot_free;
               emit_last = 1'b1;
            end
         end
         tccw_pkg::SEQ_SIGN: begin
            emit      = slot_free;
            emit_char = tccw_pkg::MINUS_CODE;
         end
         tccw_pkg::SEQ_CONVERT: begin
            // Start from the most significant digit
            if (div_status.done) idx_in = div_status.count - 1'b1;
         end
         tccw_pkg::SEQ_DIGITS: begin
            emit      = slot_free;
            emit_char = tccw_pkg::ZERO_CODE + tccw_pkg::CHAR_W'(digit);
            emit_last = (idx_ff == '0);
            if (slot_free && idx_ff != '0) idx_in = idx_ff - 1'b1;
         end
         tccw_pkg::SEQ_FILL: begin
            emit            = slot_free;
            emit_char       = tccw_pkg::BLANK_CODE;
            emit_fill       = 1'b1;
            emit_last       = 1'b1;
            cursor_cmd.home = slot_free;
         end
         default: ;
      endcase
      // Advance the cursor on every character written
      if (emit && !emit_fill) cursor_cmd.put = 1'b1;
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   assign attr_in      = (csr_chan.valid && csr_chan.ready) ? csr_chan.text_attribute : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccw_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         attr_ff      <= tccw_pkg::ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         attr_ff      <= attr_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      idx_ff  <= idx_in;
      if (emit) begin
         rsp_addr_ff <= emit_fill ? '0 : cursor_addr;
         rsp_word_ff <= {attr_ff, emit_char};
         rsp_fill_ff <= emit_fill;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.cell_address = rsp_addr_ff;
   assign rsp_chan.cell_word    = rsp_word_ff;
   assign rsp_chan.fill_all     = rsp_fill_ff;
   assign rsp_chan.last         = rsp_last_ff;

`ifndef SYNTHESIS
   // A fill request always targets cell zero
   a_fill_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fill_ff |-> rsp_addr_ff == '0)
      else $error("fill transfer with nonzero address");

   // Character writes stay on the screen
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_fill_ff |->
         (SCREEN_AREA > (1 << tccw_pkg::ADDR_W)) || (int'(rsp_addr_ff) < SCREEN_AREA))
      else $error("cell address beyond screen");

   // A real command leaves the request side closed in the cycle after it is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_chan.cmd == tccw_pkg::CMD_PUT || req_chan.cmd == tccw_pkg::CMD_PRINT
                     || req_chan.cmd == tccw_pkg::CMD_CLEAR) |=> !req_chan.ready)
      else $error("request accepted back to back");

   // Digits are sent only after the conversion has finished
   a_digits_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == tccw_pkg::SEQ_DIGITS |-> div_status.done && div_status.count != '0)
      else $error("digit output before conversion done");
`endif

endmodule

// ----- rtl/core/tccw_div10.sv -----
// Iterative divide-by-ten unit that splits a magnitude into decimal digits.
module tccw_div10 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tccw_pkg::NUMBER_W-1:0]       value,
   input  logic [tccw_pkg::DIGIT_IDX_W-1:0]    rd_index,
   output logic [tccw_pkg::DIGIT_W-1:0]        rd_digit,
   output tccw_pkg::div_status_type            status
);

   tccw_pkg::div_state_type state_ff, state_in;

   logic [tccw_pkg::NUMBER_W-1:0]     mag_ff, mag_in;
   logic [2*tccw_pkg::NUMBER_W-1:0]   prod_ff;
   logic [tccw_pkg::DIGIT_IDX_W-1:0]  count_ff, count_in;
   logic                              done_ff, done_in;
   logic [tccw_pkg::DIGIT_W-1:0]      digit_ff [tccw_pkg::DIGITS_MAX];

   logic [tccw_pkg::NUMBER_W-1:0]     quot;
   logic [tccw_pkg::NUMBER_W-1:0]     quot_x10;
   logic [tccw_pkg::NUMBER_W-1:0]     rem;
   logic                              digit_we;

   // Quotient from the registered reciprocal product, remainder by shift-add
   assign quot     = tccw_pkg::NUMBER_W'(prod_ff[2*tccw_pkg::NUMBER_W-1:tccw_pkg::RECIP_SHIFT]);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem      = mag_ff - quot_x10;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccw_pkg::DIV_IDLE:  if (start) state_in = tccw_pkg::DIV_MUL;
         tccw_pkg::DIV_MUL:   state_in = tccw_pkg::DIV_SPLIT;
         tccw_pkg::DIV_SPLIT: state_in = (quot == '0) ? tccw_pkg::DIV_IDLE : tccw_pkg::DIV_MUL;
         default:             state_in = tccw_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      mag_in   = mag_ff;
      count_in = count_ff;
      done_in  = done_ff;
      digit_we = 1'b0;
      unique case (state_ff)
         tccw_pkg::DIV_IDLE: begin
            if (start) begin
               mag_in   = value;
               count_in = '0;
               done_in  = 1'b0;
            end
         end
         tccw_pkg::DIV_SPLIT: begin
            digit_we = 1'b1;
            mag_in   = quot;
            count_in = count_ff + 1'b1;
            if (quot == '0) done_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccw_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      prod_ff <= (2*tccw_pkg::NUMBER_W)'(mag_ff) * (2*tccw_pkg::NUMBER_W)'(tccw_pkg::RECIP_TEN);
      if (digit_we) digit_ff[count_ff] <= rem[tccw_pkg::DIGIT_W-1:0];
   end

   assign rd_digit     = digit_ff[rd_index];
   assign status.done  = done_ff;
   assign status.count = count_ff;

endmodule

// ----- rtl/core/tccw_cursor.sv -----
// Cursor row/column registers with wrap and cell address generation.
module tccw_cursor #(
   parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = tccw_pkg::SCREEN_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tccw_pkg::cursor_cmd_type      cmd,
   output logic [tccw_pkg::ADDR_W-1:0]   cell_address
);

   localparam int BASE_W = tccw_pkg::ROW_W + tccw_pkg::COL_W;
   localparam logic [tccw_pkg::COL_W:0] COL_LIMIT  = (tccw_pkg::COL_W+1)'(SCREEN_COLUMNS);
   localparam logic [tccw_pkg::ROW_W:0] ROW_LIMIT  = (tccw_pkg::ROW_W+1)'(SCREEN_ROWS);
   localparam logic [BASE_W-1:0]        COL_STRIDE = BASE_W'(SCREEN_COLUMNS);

   logic [tccw_pkg::ROW_W-1:0] row_ff, row_in;
   logic [tccw_pkg::COL_W-1:0] col_ff, col_in;
   logic [tccw_pkg::COL_W:0]   col_next;
   logic [tccw_pkg::ROW_W:0]   row_next;
   logic [tccw_pkg::ROW_W-1:0] row_adv;
   logic [BASE_W-1:0]          row_base;
   logic [BASE_W-1:0]          addr_sum;

   assign col_next = {1'b0, col_ff} + 1'b1;
   assign row_next = {1'b0, row_ff} + 1'b1;
   assign row_adv  = (row_next >= ROW_LIMIT) ? '0 : row_next[tccw_pkg::ROW_W-1:0];

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.home) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.newline) begin
         row_in = row_adv;
         col_in = '0;
      end else if (cmd.put) begin
         if (col_next >= COL_LIMIT) begin
            row_in = row_adv;
            col_in = '0;
         end else begin
            col_in = col_next[tccw_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign row_base     = BASE_W'(row_ff) * COL_STRIDE;
   assign addr_sum     = row_base + BASE_W'(col_ff);
   assign cell_address = addr_sum[tccw_pkg::ADDR_W-1:0];

endmodule
